FILE: hw/rtl/mtfpl_pkg.sv
// Shared constants and types for the move-to-front position list.
// Holds default sizes, command codes, cell operation codes and field widths.
// No dependencies.
package mtfpl_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int COLOR_BITS_DEF = 16;

	localparam int CMD_W       = 2;
	localparam int IN_COLOR_W  = 16;
	localparam int POS_W       = 9;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_CLEAR  = 2'd0;
	localparam cmd_t CMD_APPEND = 2'd1;
	localparam cmd_t CMD_QUERY  = 2'd2;

	typedef logic [2:0] cell_op_t;

	localparam cell_op_t OP_HOLD   = 3'd0;
	localparam cell_op_t OP_APPEND = 3'd1;
	localparam cell_op_t OP_ROTATE = 3'd2;
	localparam cell_op_t OP_DROP   = 3'd3;
	localparam cell_op_t OP_INSERT = 3'd4;

endpackage

FILE: hw/rtl/mtfpl_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mtfpl_pkg for the field widths.
interface mtfpl_cmd_if;
	import mtfpl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [IN_COLOR_W-1:0] color;

	modport source (output valid, output command, output color, input ready);
	modport sink   (input valid, input command, input color, output ready);
endinterface

interface mtfpl_res_if;
	import mtfpl_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             found;
	logic             overflow;

	modport source (output valid, output position, output found, output overflow, input ready);
	modport sink   (input valid, input position, input found, input overflow, output ready);
endinterface

FILE: hw/rtl/mtfpl_cell.sv
// One list cell: holds a single color and takes a new one from its neighbors,
// the head cell or the broadcast color as the operation code says.
// Depends on mtfpl_pkg for the cell operation codes.
module mtfpl_cell #(
	parameter int COLOR_BITS = mtfpl_pkg::COLOR_BITS_DEF,
	parameter int CNT_W      = $clog2(mtfpl_pkg::DEPTH_DEF + 1),
	parameter int INDEX      = 0
) (
	input  logic                      clk,
	input  mtfpl_pkg::cell_op_t       op,
	input  logic [CNT_W-1:0]          len,
	input  logic [COLOR_BITS-1:0]     color,
	input  logic [COLOR_BITS-1:0]     head,
	input  logic [COLOR_BITS-1:0]     left,
	input  logic [COLOR_BITS-1:0]     right,
	output logic [COLOR_BITS-1:0]     entry
);
	import mtfpl_pkg::*;

	logic [COLOR_BITS-1:0] entry_q;
	logic                  is_tail;
	logic                  is_next;

	assign is_tail = (len == CNT_W'(INDEX + 1));
	assign is_next = (len == CNT_W'(INDEX));

	always_ff @(posedge clk) begin
		unique case (op)
			OP_APPEND: begin
				if (is_next) begin
					entry_q <= color;
				end
			end
			OP_ROTATE: entry_q <= is_tail ? head : right;
			OP_DROP:   entry_q <= right;
			OP_INSERT: entry_q <= left;
			default:   entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule

FILE: hw/rtl/move_to_front_position_list.sv
// Move-to-front position list: a row of DEPTH cells with a compare at the head.
// Clear and an append that fits keep the block idle; the next command can be
// accepted the cycle after. A query on n entries runs n scan steps (rotate, or drop
// at the match), an insert when found, then emit, which waits for a free output
// register; no command is accepted meanwhile. A dropped append goes to emit.
// Reset empties the list and clears the overflow flag; cell contents are not reset.
module move_to_front_position_list #(
	parameter int DEPTH      = mtfpl_pkg::DEPTH_DEF,
	parameter int COLOR_BITS = mtfpl_pkg::COLOR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	mtfpl_cmd_if.sink          req,
	mtfpl_res_if.source        rsp
);
	import mtfpl_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_INSERT = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      step_q;
	logic                  ovf_seen_q;
	logic [COLOR_BITS-1:0] color_q;

	logic [POS_W-1:0]      res_pos_q;
	logic                  res_found_q;
	logic                  res_ovf_q;

	logic                  out_valid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic                  out_found_q;
	logic                  out_ovf_q;

	logic [COLOR_BITS-1:0] ent     [DEPTH];
	logic [COLOR_BITS-1:0] left_w  [DEPTH];
	logic [COLOR_BITS-1:0] right_w [DEPTH];

	cell_op_t              cell_op;
	logic [CNT_W-1:0]      cell_len;
	logic [COLOR_BITS-1:0] cell_color;
	logic [COLOR_BITS-1:0] in_color;

	logic                  accept;
	logic                  full;
	logic                  match;
	logic                  last_step;
	logic                  out_free;

	assign in_color  = COLOR_BITS'(req.color);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign match     = !res_found_q && (ent[0] == color_q);
	assign last_step = ((step_q + CNT_W'(1)) == count_q);
	assign out_free  = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		cell_op    = OP_HOLD;
		cell_len   = len_q;
		cell_color = color_q;
		unique case (state_q)
			ST_IDLE: begin
				cell_len   = count_q;
				cell_color = in_color;
				if (accept && req.command == CMD_APPEND && !full) begin
					cell_op = OP_APPEND;
				end
			end
			ST_SCAN:   cell_op = match ? OP_DROP : OP_ROTATE;
			ST_INSERT: cell_op = OP_INSERT;
			default:   cell_op = OP_HOLD;
		endcase
	end

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		if (gi == 0) begin : g_first
			assign left_w[gi] = cell_color;
		end else begin : g_inner_left
			assign left_w[gi] = ent[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign right_w[gi] = ent[gi];
		end else begin : g_inner_right
			assign right_w[gi] = ent[gi+1];
		end

		mtfpl_cell #(
			.COLOR_BITS (COLOR_BITS),
			.CNT_W      (CNT_W),
			.INDEX      (gi)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.len   (cell_len),
			.color (cell_color),
			.head  (ent[0]),
			.left  (left_w[gi]),
			.right (right_w[gi]),
			.entry (ent[gi])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			len_q       <= '0;
			step_q      <= '0;
			ovf_seen_q  <= 1'b0;
			res_found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.command)
							CMD_CLEAR: begin
								count_q    <= '0;
								ovf_seen_q <= 1'b0;
							end
							CMD_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									ovf_seen_q  <= 1'b1;
									res_found_q <= 1'b0;
									state_q     <= ST_EMIT;
								end
							end
							CMD_QUERY: begin
								step_q      <= '0;
								len_q       <= count_q;
								res_found_q <= 1'b0;
								state_q     <= (count_q == '0) ? ST_EMIT : ST_SCAN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					step_q <= step_q + CNT_W'(1);
					if (match) begin
						res_found_q <= 1'b1;
						len_q       <= len_q - CNT_W'(1);
					end
					if (last_step) begin
						state_q <= (res_found_q || match) ? ST_INSERT : ST_EMIT;
					end
				end
				ST_INSERT: state_q <= ST_EMIT;
				default: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			color_q   <= in_color;
			res_pos_q <= '0;
			res_ovf_q <= (req.command == CMD_APPEND) ? 1'b1 : ovf_seen_q;
		end else if (state_q == ST_SCAN && match) begin
			res_pos_q <= POS_W'(step_q + CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_pos_q   <= res_pos_q;
			out_found_q <= res_found_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.position = out_pos_q;
	assign rsp.found    = out_found_q;
	assign rsp.overflow = out_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond list depth");

	a_single_drop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (len_q == count_q || (len_q + CNT_W'(1)) == count_q))
		else $error("more than one entry dropped during a scan");

	a_insert_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> res_found_q && len_q + CNT_W'(1) == count_q)
		else $error("insert without a matching entry");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && last_step |=> state_q == ST_INSERT || state_q == ST_EMIT)
		else $error("scan did not finish after its last step");

endmodule

FILE: test/move_to_front_position_list_test.sv
// Testbench for move_to_front_position_list: a directed table, then random command
// episodes with random idling; every result checked against its typed row or
// a move-to-front predictor. Depends on mtfpl_pkg, mtfpl_if.sv and the RTL top level.
module move_to_front_position_list_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mtfpl_pkg::*;

	localparam int   DEPTH       = DEPTH_DEF;
	localparam int   ITEMS       = 1350;
	localparam int   MAX_WAIT    = 18;
	localparam int   RUN_LIMIT   = 3_000_000;
	localparam int   DRAIN       = DEPTH + 16;
	localparam cmd_t CMD_IGNORED = 2'd3;

	typedef logic [IN_COLOR_W-1:0] color_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
		logic             overflow;
	} result_t;

	typedef struct packed {
		cmd_t    command;
		color_t  color;
		logic    typed;
		result_t want;
	} stim_row_t;

	localparam int N_ROWS = 21;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{CMD_QUERY,   16'h1234, 1'b1, '{9'd0, 1'b0, 1'b0}},
		'{CMD_IGNORED, 16'hFFFF, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'h0000, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'hFFFF, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'h8001, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'hFFFF, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'h00FF, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'h0000, 1'b1, '{9'd1, 1'b1, 1'b0}},
		'{CMD_QUERY,   16'h00FF, 1'b1, '{9'd5, 1'b1, 1'b0}},
		'{CMD_QUERY,   16'hFFFF, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'hFFFF, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'h8001, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'h7FFE, 1'b1, '{9'd0, 1'b0, 1'b0}},
		'{CMD_IGNORED, 16'h0000, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'h7FFE, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'h7FFE, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_CLEAR,   16'h5A5A, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'hFFFF, 1'b1, '{9'd0, 1'b0, 1'b0}},
		'{CMD_APPEND,  16'hA5A5, 1'b0, '{9'd0, 1'b0, 1'b0}},
		'{CMD_QUERY,   16'hA5A5, 1'b1, '{9'd1, 1'b1, 1'b0}},
		'{CMD_QUERY,   16'h5A5A, 1'b1, '{9'd0, 1'b0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	mtfpl_cmd_if req_ch ();
	mtfpl_res_if rsp_ch ();

	move_to_front_position_list uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	color_t  palette [DEPTH];
	int      palette_len = 0;
	bit      drop_seen   = 1'b0;
	result_t results_due [$];
	int      errors      = 0;
	int      sent        = 0;
	int      cycle_count = 0;
	bit      no_idle     = 1'b0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic mtf_predict(input cmd_t cmd, input color_t col, output bit emits,
			output result_t res);
		int hit;
		emits = 1'b0;
		res   = '0;
		hit   = -1;
		case (cmd)
			CMD_CLEAR: begin
				palette_len = 0;
				drop_seen   = 1'b0;
			end
			CMD_APPEND: begin
				if (palette_len < DEPTH) begin
					palette[palette_len] = col;
					palette_len++;
				end else begin
					drop_seen    = 1'b1;
					emits        = 1'b1;
					res.overflow = 1'b1;
				end
			end
			CMD_QUERY: begin
				for (int i = 0; i < palette_len; i++) begin
					if (palette[i] == col) begin
						hit = i;
						break;
					end
				end
				emits        = 1'b1;
				res.overflow = drop_seen;
				if (hit >= 0) begin
					for (int i = hit; i > 0; i--)
						palette[i] = palette[i-1];
					palette[0]   = col;
					res.position = POS_W'(hit + 1);
					res.found    = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_cmd(input cmd_t cmd, input color_t col, input bit typed,
			input result_t want);
		int      gap;
		bit      emits;
		result_t got;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.color   <= col;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		mtf_predict(cmd, col, emits, got);
		if (emits)
			results_due.insert(results_due.size(), typed ? want : got);
		if (cmd != CMD_IGNORED)
			sent++;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic color_t near_color(input bit narrow, input color_t base);
		return narrow ? (base ^ color_t'($urandom_range(0, 3))) : color_t'($urandom);
	endfunction

	initial begin
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
	end

	// result side: random stall, compare with oldest expectation
	initial begin
		int      stall;
		result_t want;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result position=%0d found=%0b overflow=%0b", $time,
					rsp_ch.position, rsp_ch.found, rsp_ch.overflow);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (rsp_ch.position !== want.position) begin
					$display("%0t: position expected %0d actual %0d", $time,
						want.position, rsp_ch.position);
					errors++;
				end
				if (rsp_ch.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time,
						want.found, rsp_ch.found);
					errors++;
				end
				if (rsp_ch.overflow !== want.overflow) begin
					$display("%0t: overflow expected %0b actual %0b", $time,
						want.overflow, rsp_ch.overflow);
					errors++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		while (cycle_count < RUN_LIMIT)
			@(posedge clk) cycle_count++;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int     episode;
		int     n_app;
		int     n_qry;
		int     pick;
		bit     full_run;
		bit     narrow;
		color_t base;
		episode        = 0;
		req_ch.valid   = 1'b0;
		req_ch.command = CMD_CLEAR;
		req_ch.color   = '0;
		@(posedge arst_n);
		@(negedge clk);
		@(negedge clk);

		for (int r = 0; r < N_ROWS; r++)
			push_cmd(DIRECTED[r].command, DIRECTED[r].color, DIRECTED[r].typed,
				DIRECTED[r].want);
		wait_all_results();

		while (sent < ITEMS) begin
			full_run = (episode == 1) || ($urandom_range(0, 59) == 0);
			no_idle  = ($urandom_range(0, 3) == 0);
			narrow   = 1'($urandom_range(0, 1));
			base     = color_t'($urandom);
			if (full_run || $urandom_range(0, 4) != 0)
				push_cmd(CMD_CLEAR, color_t'($urandom), 1'b0, '0);
			if (full_run)
				n_app = DEPTH - palette_len + $urandom_range(1, 3);
			else if ($urandom_range(0, 7) == 0)
				n_app = $urandom_range(13, 40);
			else
				n_app = $urandom_range(1, 12);
			for (int k = 0; k < n_app; k++)
				push_cmd(CMD_APPEND, near_color(narrow, base), 1'b0, '0);
			if (full_run && palette_len > 0)
				push_cmd(CMD_QUERY, palette[palette_len-1], 1'b0, '0);
			n_qry = $urandom_range(4, 20);
			for (int k = 0; k < n_qry; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					push_cmd(CMD_IGNORED, color_t'($urandom), 1'b0, '0);
				else if (pick < 6)
					push_cmd(CMD_CLEAR, color_t'($urandom), 1'b0, '0);
				else if (pick < 16)
					push_cmd(CMD_APPEND, near_color(narrow, base), 1'b0, '0);
				else if (pick < 36 || palette_len == 0)
					push_cmd(CMD_QUERY, near_color(narrow, base), 1'b0, '0);
				else
					push_cmd(CMD_QUERY, palette[$urandom_range(0, palette_len - 1)],
						1'b0, '0);
			end
			episode++;
		end

		wait_all_results();
		repeat (DRAIN) @(negedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: move_to_front_position_list.f
hw/rtl/mtfpl_pkg.sv
hw/rtl/mtfpl_if.sv
hw/rtl/mtfpl_cell.sv
hw/rtl/move_to_front_position_list.sv
test/move_to_front_position_list_test.sv
